// ===== rtl/tensor_axis_reduce_top_assert.svh =====
// assertion macros for the axis reduction block
`ifndef TENSOR_AXIS_REDUCE_TOP_ASSERT_SVH
`define TENSOR_AXIS_REDUCE_TOP_ASSERT_SVH
// implication checked on every clock edge outside reset
`define TAR_ASSERT_IMPL(label, clk_s, rst_n_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define TAR_ASSERT_NEXT(label, clk_s, rst_n_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== rtl/tar_pkg.sv =====
// shared types and constants of the axis reduction block
`default_nettype none
package tar_pkg;
	localparam int unsigned INNER_MAX_DEF = 1024;
	localparam int unsigned AXIS_MAX_DEF = 16777216;
	localparam int unsigned OUTER_MAX_DEF = 16777216;
	localparam int unsigned VAL_W = 56;
	localparam int unsigned ELEM_W = 32;
	localparam int unsigned IDX_W = 24;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 25;
	localparam int unsigned QUOT_W = VAL_W;

	typedef enum logic [1:0] {
		MODE_SUM  = 2'd0,
		MODE_MEAN = 2'd1,
		MODE_MAX  = 2'd2,
		MODE_MIN  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_OP_MODE     = 2'd0,
		REG_OUTER_COUNT = 2'd1,
		REG_AXIS_LENGTH = 2'd2,
		REG_INNER_COUNT = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		DIV_IDLE = 2'd0,
		DIV_RUN  = 2'd1,
		DIV_DONE = 2'd2
	} div_state_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [IDX_W-1:0]        index;
		logic                    sat;
		logic                    last;
	} result_t;
endpackage
`default_nettype wire

// ===== rtl/tar_stream_if.sv =====
// valid/ready channel carrying a payload
`default_nettype none
interface tar_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/tar_cfg_if.sv =====
// configuration write channel
`default_nettype none
interface tar_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [tar_pkg::CFG_IDX_W:0]        index;
	logic [tar_pkg::CFG_DATA_W-1:0]     wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

// ===== rtl/tar_divider.sv =====
// sequential signed divider, one quotient bit per cycle, truncating toward zero
`default_nettype none
module tar_divider #(
	parameter int unsigned DIV_W = 25
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire logic signed [tar_pkg::VAL_W-1:0]     dividend,
	input  wire logic [DIV_W-1:0]                     divisor,
	output logic                                      done,
	output logic signed [tar_pkg::VAL_W-1:0]          quotient,
	input  wire logic                                 ack
);
	localparam int unsigned W = tar_pkg::VAL_W;
	localparam int unsigned CW = $clog2(W + 1);

	tar_pkg::div_state_t state_q, state_d;
	logic [W-1:0]     num_q;
	logic [W-1:0]     quo_q;
	logic [DIV_W:0]   rem_q;
	logic [DIV_W-1:0] den_q;
	logic             neg_q;
	logic [CW-1:0]    cnt_q;
	logic [DIV_W:0]   rem_sh;
	logic [DIV_W+1:0] rem_sub;

	assign rem_sh = {rem_q[DIV_W-1:0], num_q[W-1]};
	assign rem_sub = {1'b0, rem_sh} - {2'b00, den_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			tar_pkg::DIV_IDLE: if (start) state_d = tar_pkg::DIV_RUN;
			tar_pkg::DIV_RUN: if (cnt_q == CW'(W - 1)) state_d = tar_pkg::DIV_DONE;
			tar_pkg::DIV_DONE: if (ack) state_d = tar_pkg::DIV_IDLE;
			default: state_d = tar_pkg::DIV_IDLE;
		endcase
	end

	always_comb begin
		done = (state_q == tar_pkg::DIV_DONE);
		quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tar_pkg::DIV_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == tar_pkg::DIV_RUN) cnt_q <= cnt_q + CW'(1);
			else cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tar_pkg::DIV_IDLE && start) begin
			num_q <= dividend[W-1] ? W'(-dividend) : W'(dividend);
			neg_q <= dividend[W-1];
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (state_q == tar_pkg::DIV_RUN) begin
			num_q <= {num_q[W-2:0], 1'b0};
			if (!rem_sub[DIV_W+1]) begin
				rem_q <= rem_sub[DIV_W:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/tensor_axis_reduce_top.sv =====
// reduction of a streamed tensor along one axis with accumulator memory
// results pass through stage 1 and the output register; mean results also wait on the divider
// one element per cycle while the result drains; an element closing an axis run holds the input
// while it is in stage 1, and in mean mode also while the divider runs
// one read and one write port on the accumulator memory, forwarding from the write stage
// reset clears positions and registers to op_mode 0, counts 1; memory is not cleared
`default_nettype none
module tensor_axis_reduce_top #(
	parameter int unsigned INNER_MAX = tar_pkg::INNER_MAX_DEF,
	parameter int unsigned AXIS_MAX  = tar_pkg::AXIS_MAX_DEF,
	parameter int unsigned OUTER_MAX = tar_pkg::OUTER_MAX_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	tar_cfg_if.sink      cfg,
	tar_stream_if.sink   elem,
	tar_stream_if.source result
);
	localparam int unsigned VW = tar_pkg::VAL_W;
	localparam int unsigned XW = tar_pkg::IDX_W;
	localparam int unsigned AW = (INNER_MAX > 1) ? $clog2(INNER_MAX) : 1;
	localparam int unsigned IW = $clog2(INNER_MAX + 1);
	localparam int unsigned NW = $clog2(AXIS_MAX + 1);
	localparam int unsigned OW = $clog2(OUTER_MAX + 1);
	localparam int unsigned EW = VW + XW + 1;
	localparam logic signed [VW:0] VMAX = (VW+1)'((64'sd1 <<< (VW - 1)) - 1);
	localparam logic signed [VW:0] VMIN = -(VMAX) - (VW+1)'(1);

	tar_pkg::mode_t mode_q;
	logic [24:0] outer_q, axis_q;
	logic [10:0] inner_q;
	logic [IW-1:0] n_in;
	logic [NW-1:0] n_ax;
	logic [OW-1:0] n_out;
	logic [IW-1:0] ipos_q;
	logic [NW-1:0] apos_q;
	logic [OW-1:0] opos_q;

	logic [EW-1:0] mem [INNER_MAX];
	logic [EW-1:0] rd_q;

	logic          v_s1;
	logic [AW-1:0] k_s1;
	logic signed [tar_pkg::ELEM_W-1:0] x_s1;
	logic          first_s1, emit_s1, last_s1;
	logic [XW-1:0] apos_s1;
	tar_pkg::mode_t mode_s1;

	logic          wv_q;
	logic [AW-1:0] wk_q;
	logic [EW-1:0] wd_q;

	logic          outv_q;
	tar_pkg::result_t out_q;
	logic          div_busy_q, div_done, div_start;
	logic signed [VW-1:0] div_quo;
	logic [24:0]   div_den;

	logic accept, cfg_fire, wrap, stall;
	logic [EW-1:0] cur;
	logic signed [VW-1:0] cv, nv;
	logic [XW-1:0] ci, ni;
	logic cs, ns;
	logic signed [VW:0] sum;
	logic signed [VW-1:0] xe;

	function automatic logic [31:0] clampc(input logic [31:0] v, input logic [31:0] lim);
		logic [31:0] r;
		r = v;
		if (v == 32'd0) r = 32'd1;
		else if (v > lim) r = lim;
		return r;
	endfunction

	assign n_in = IW'(clampc(32'(inner_q), 32'(INNER_MAX)));
	assign n_ax = NW'(clampc(32'(axis_q), 32'(AXIS_MAX)));
	assign n_out = OW'(clampc(32'(outer_q), 32'(OUTER_MAX)));
	assign div_den = 25'(n_ax);

	// output register must be free or draining and stage 1 must not hold an axis-closing element; mean waits on divider
	assign stall = div_busy_q || (outv_q && !result.ready) || (v_s1 && emit_s1);
	assign elem.ready = !stall;
	assign accept = elem.valid && elem.ready;
	assign cfg.ready = 1'b1;
	assign cfg_fire = cfg.valid && (cfg.index[tar_pkg::CFG_IDX_W] == 1'b0);
	assign wrap = (ipos_q >= n_in) || (apos_q >= n_ax) || (opos_q >= n_out);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= tar_pkg::MODE_SUM;
			outer_q <= 25'd1;
			axis_q <= 25'd1;
			inner_q <= 11'd1;
		end else if (cfg_fire) begin
			case (tar_pkg::reg_idx_t'(cfg.index[tar_pkg::CFG_IDX_W-1:0]))
				tar_pkg::REG_OP_MODE: mode_q <= tar_pkg::mode_t'(cfg.wdata[1:0]);
				tar_pkg::REG_OUTER_COUNT: outer_q <= cfg.wdata;
				tar_pkg::REG_AXIS_LENGTH: axis_q <= cfg.wdata;
				tar_pkg::REG_INNER_COUNT: inner_q <= cfg.wdata[10:0];
				default: mode_q <= mode_q;
			endcase
		end
	end

	// position counters and stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		logic [IW-1:0] ip;
		logic [NW-1:0] ap;
		logic [OW-1:0] op;
		if (!arst_n) begin
			ipos_q <= '0;
			apos_q <= '0;
			opos_q <= '0;
			v_s1 <= 1'b0;
		end else if (cfg_fire) begin
			ipos_q <= '0;
			apos_q <= '0;
			opos_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (accept) begin
				ip = wrap ? '0 : ipos_q;
				ap = wrap ? '0 : apos_q;
				op = wrap ? '0 : opos_q;
				if (ip + IW'(1) >= n_in) begin
					ipos_q <= '0;
					if (ap + NW'(1) >= n_ax) begin
						apos_q <= '0;
						opos_q <= (op + OW'(1) >= n_out) ? '0 : op + OW'(1);
					end else begin
						apos_q <= ap + NW'(1);
						opos_q <= op;
					end
				end else begin
					ipos_q <= ip + IW'(1);
					apos_q <= ap;
					opos_q <= op;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [IW-1:0] ip;
		logic [NW-1:0] ap;
		logic [OW-1:0] op;
		if (accept) begin
			ip = wrap ? '0 : ipos_q;
			ap = wrap ? '0 : apos_q;
			op = wrap ? '0 : opos_q;
			k_s1 <= AW'(ip);
			x_s1 <= elem.data;
			first_s1 <= (ap == '0);
			emit_s1 <= (ap == n_ax - NW'(1));
			last_s1 <= (op == n_out - OW'(1)) && (ip == n_in - IW'(1));
			apos_s1 <= XW'(ap);
			mode_s1 <= mode_q;
			rd_q <= mem[AW'(ip)];
		end
	end

	// read-modify-write with forwarding from the write register
	always_comb begin
		cur = (wv_q && wk_q == k_s1) ? wd_q : rd_q;
		cv = $signed(cur[EW-1 -: VW]);
		ci = cur[XW:1];
		cs = cur[0];
		xe = VW'(x_s1);
		sum = (VW+1)'(cv) + (VW+1)'(xe);
		nv = cv;
		ni = ci;
		ns = cs;
		if (first_s1) begin
			nv = xe;
			ni = '0;
			ns = 1'b0;
		end else begin
			case (mode_s1)
				tar_pkg::MODE_SUM, tar_pkg::MODE_MEAN: begin
					if (sum > VMAX) begin
						nv = VMAX[VW-1:0];
						ns = 1'b1;
					end else if (sum < VMIN) begin
						nv = VMIN[VW-1:0];
						ns = 1'b1;
					end else begin
						nv = sum[VW-1:0];
					end
				end
				tar_pkg::MODE_MAX: if (xe > cv) begin
					nv = xe;
					ni = apos_s1;
				end
				tar_pkg::MODE_MIN: if (xe < cv) begin
					nv = xe;
					ni = apos_s1;
				end
				default: nv = cv;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) wv_q <= 1'b0;
		else wv_q <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			mem[k_s1] <= {nv, ni, ns};
			wk_q <= k_s1;
			wd_q <= {nv, ni, ns};
		end
	end

	assign div_start = v_s1 && emit_s1 && (mode_s1 == tar_pkg::MODE_MEAN);

	tar_divider #(.DIV_W(25)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(nv),
		.divisor(div_den),
		.done(div_done),
		.quotient(div_quo),
		.ack(div_done)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outv_q <= 1'b0;
			div_busy_q <= 1'b0;
		end else begin
			if (outv_q && result.ready) outv_q <= 1'b0;
			if (div_start) div_busy_q <= 1'b1;
			if (div_done) begin
				div_busy_q <= 1'b0;
				outv_q <= 1'b1;
			end else if (v_s1 && emit_s1 && mode_s1 != tar_pkg::MODE_MEAN) begin
				outv_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_done) begin
			out_q.value <= div_quo;
		end else if (v_s1 && emit_s1) begin
			out_q.value <= nv;
			out_q.index <= (mode_s1 == tar_pkg::MODE_MAX || mode_s1 == tar_pkg::MODE_MIN)
				? ni : '0;
			out_q.sat <= (mode_s1 == tar_pkg::MODE_SUM || mode_s1 == tar_pkg::MODE_MEAN)
				? ns : 1'b0;
			out_q.last <= last_s1;
		end
	end

	assign result.valid = outv_q;
	assign result.data = out_q;
endmodule
`default_nettype wire

// ===== rtl/tar_checker.sv =====
// port-level checks of the axis reduction block and their binding
`default_nettype none
`include "tensor_axis_reduce_top_assert.svh"
module tar_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire tar_pkg::result_t  out_data,
	input wire logic              in_ready
);
	`TAR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`TAR_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_data))
	`TAR_ASSERT_IMPL(a_no_take_when_full, clk, arst_n, out_valid && !out_ready, !in_ready)
	`TAR_ASSERT_IMPL(a_idx_sat_excl, clk, arst_n, out_valid, !(out_data.sat && (out_data.index != '0)))
endmodule

bind tensor_axis_reduce_top tar_checker u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.out_data(result.data),
	.in_ready(elem.ready)
);
`default_nettype wire
